@@ rtl/mmt_pkg.sv @@
// Shared constants and types for the multiset mex tracker.
`timescale 1ns / 1ps
`default_nettype none

package mmt_pkg;

    localparam int MAX_LENGTH = 1024;
    localparam int LEN_W      = $clog2(MAX_LENGTH + 1);
    localparam int POS_W      = $clog2(MAX_LENGTH);
    localparam int VAL_W      = 32;
    localparam int CNT_W      = 11;
    localparam int CNT_DEPTH  = MAX_LENGTH + 1;
    localparam int CNT_AW     = $clog2(CNT_DEPTH);
    localparam int WORD_W     = 32;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int WORDS      = (CNT_DEPTH + WORD_W - 1) / WORD_W;
    localparam int WORD_AW    = $clog2(WORDS);

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_LENGTH);

    typedef struct packed {
        logic               we;
        logic [WORD_AW-1:0] word;
        logic               full;
    } flag_upd_t;

endpackage

`default_nettype wire

@@ rtl/mmt_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/mmt_scan.sv @@
// Word-full flags over the presence bitmap and the two-level first-zero search.
`timescale 1ns / 1ps
`default_nettype none

module mmt_scan (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mmt_pkg::flag_upd_t            upd,
    output logic      [mmt_pkg::WORD_AW-1:0]   open_word,
    input  wire logic [mmt_pkg::WORD_AW-1:0]   word_idx,
    input  wire logic [mmt_pkg::WORD_W-1:0]    word_data,
    input  wire logic [mmt_pkg::LEN_W-1:0]     len,
    output logic      [mmt_pkg::LEN_W-1:0]     mex
);

    import mmt_pkg::*;

    logic [WORDS-1:0]   full_reg;
    logic [BIT_W-1:0]   zero_bit;
    logic [LEN_W-1:0]   first_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= '0;
        end
        else if (upd.we)
        begin
            full_reg[upd.word] <= upd.full;
        end
    end

    always_comb
    begin
        open_word = WORD_AW'(WORDS - 1);
        for (int i = WORDS - 1; i >= 0; i--)
        begin
            if (!full_reg[i])
            begin
                open_word = WORD_AW'(i);
            end
        end
    end

    always_comb
    begin
        zero_bit = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!word_data[i])
            begin
                zero_bit = BIT_W'(i);
            end
        end
        first_zero = LEN_W'({word_idx, zero_bit});
        mex = (first_zero >= len) ? len : first_zero;
    end

endmodule

`default_nettype wire

@@ rtl/multiset_mex_tracker.sv @@
// Top level of the multiset mex tracker: sequencer and the three state memories.
//
//  Channel  Signals                              Beat taken when
//  -------  -----------------------------------  ---------------------------
//  item     start, busy, mode, position,         start high and busy low
//           new_value
//  result   done, mex                            every cycle done is high
//  config   cfg_valid, cfg_ready, cfg_data       cfg_valid and cfg_ready high
//
// A load steps through S_UP_RD, S_UP_WR, S_SCAN_RD and S_SCAN_OUT after the accept;
// an update first passes S_OLD_RD and S_DN_WR, or goes from S_OLD_RD to S_SCAN_RD
// when it writes the value held. done is registered from S_SCAN_OUT; a new item is
// taken only in S_IDLE. The single-port count and presence memories, read and
// written back one value at a time, set this sequence. After reset the block clears
// both, holding busy high; configuration beats are taken at any time.
// The receiver cannot stall: done is high for exactly one cycle per item.
`timescale 1ns / 1ps
`default_nettype none

module multiset_mex_tracker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        mode,
    input  wire logic [mmt_pkg::POS_W-1:0]   position,
    input  wire logic [mmt_pkg::VAL_W-1:0]   new_value,
    output logic                             done,
    output logic      [mmt_pkg::LEN_W-1:0]   mex,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [mmt_pkg::LEN_W-1:0]   cfg_data
);

    import mmt_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_OLD_RD,
        S_DN_WR,
        S_UP_RD,
        S_UP_WR,
        S_SCAN_RD,
        S_SCAN_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_AW-1:0]   clear_cnt_reg, clear_cnt_next;
    logic                done_reg, done_next;
    logic [LEN_W-1:0]    mex_reg, mex_next;
    logic [LEN_W-1:0]    length_reg;

    logic [POS_W-1:0]    pos_reg;
    logic [LEN_W-1:0]    val_reg;
    logic [LEN_W-1:0]    len_eff_reg;
    logic [LEN_W-1:0]    old_reg;
    logic [WORD_AW-1:0]  word_idx_reg;

    logic                accept;
    logic [LEN_W-1:0]    len_eff;
    logic [LEN_W-1:0]    val_clamped;

    logic                elem_en, elem_we;
    logic [POS_W-1:0]    elem_addr;
    logic [LEN_W-1:0]    elem_wdata, elem_rdata;

    logic                cnt_en, cnt_we;
    logic [CNT_AW-1:0]   cnt_addr;
    logic [CNT_W-1:0]    cnt_wdata, cnt_rdata;

    logic                pres_en, pres_we;
    logic [WORD_AW-1:0]  pres_addr;
    logic [WORD_W-1:0]   pres_wdata, pres_rdata;

    flag_upd_t           flag_upd;
    logic [WORD_AW-1:0]  open_word;
    logic [LEN_W-1:0]    scan_mex;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign mex       = mex_reg;

    always_comb
    begin
        if (length_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (length_reg > LEN_W'(MAX_LENGTH))
        begin
            len_eff = LEN_W'(MAX_LENGTH);
        end
        else
        begin
            len_eff = length_reg;
        end
        val_clamped = (new_value > VAL_W'(len_eff)) ? len_eff : LEN_W'(new_value);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            length_reg <= cfg_data;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clear_cnt_next = clear_cnt_reg;
        done_next      = 1'b0;
        mex_next       = mex_reg;

        elem_en    = 1'b0;
        elem_we    = 1'b0;
        elem_addr  = pos_reg;
        elem_wdata = val_reg;

        cnt_en    = 1'b0;
        cnt_we    = 1'b0;
        cnt_addr  = CNT_AW'(val_reg);
        cnt_wdata = '0;

        pres_en    = 1'b0;
        pres_we    = 1'b0;
        pres_addr  = WORD_AW'(val_reg >> BIT_W);
        pres_wdata = pres_rdata;

        flag_upd = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_en    = 1'b1;
                cnt_we    = 1'b1;
                cnt_addr  = clear_cnt_reg;
                cnt_wdata = '0;
                if (clear_cnt_reg < CNT_AW'(WORDS))
                begin
                    pres_en    = 1'b1;
                    pres_we    = 1'b1;
                    pres_addr  = WORD_AW'(clear_cnt_reg);
                    pres_wdata = '0;
                end
                clear_cnt_next = clear_cnt_reg + 1'b1;
                if (clear_cnt_reg == CNT_AW'(CNT_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    elem_en    = 1'b1;
                    elem_addr  = position;
                    state_next = mode ? S_OLD_RD : S_UP_RD;
                end
            end
            S_OLD_RD:
            begin
                if (elem_rdata == val_reg)
                begin
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    cnt_en     = 1'b1;
                    cnt_addr   = CNT_AW'(elem_rdata);
                    pres_en    = 1'b1;
                    pres_addr  = WORD_AW'(elem_rdata >> BIT_W);
                    state_next = S_DN_WR;
                end
            end
            S_DN_WR:
            begin
                cnt_en    = 1'b1;
                cnt_we    = 1'b1;
                cnt_addr  = CNT_AW'(old_reg);
                cnt_wdata = (cnt_rdata != '0) ? cnt_rdata - 1'b1 : '0;
                pres_en   = 1'b1;
                pres_we   = 1'b1;
                pres_addr = WORD_AW'(old_reg >> BIT_W);
                pres_wdata[old_reg[BIT_W-1:0]] = (cnt_wdata != '0);
                flag_upd.we   = 1'b1;
                flag_upd.word = pres_addr;
                flag_upd.full = &pres_wdata;
                state_next    = S_UP_RD;
            end
            S_UP_RD:
            begin
                cnt_en     = 1'b1;
                pres_en    = 1'b1;
                state_next = S_UP_WR;
            end
            S_UP_WR:
            begin
                cnt_en    = 1'b1;
                cnt_we    = 1'b1;
                cnt_wdata = (cnt_rdata != COUNT_MAX) ? cnt_rdata + 1'b1 : cnt_rdata;
                pres_en   = 1'b1;
                pres_we   = 1'b1;
                pres_wdata[val_reg[BIT_W-1:0]] = 1'b1;
                flag_upd.we   = 1'b1;
                flag_upd.word = pres_addr;
                flag_upd.full = &pres_wdata;
                state_next    = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                elem_en    = 1'b1;
                elem_we    = 1'b1;
                pres_en    = 1'b1;
                pres_addr  = open_word;
                state_next = S_SCAN_OUT;
            end
            S_SCAN_OUT:
            begin
                done_next  = 1'b1;
                mex_next   = scan_mex;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clear_cnt_reg <= '0;
            done_reg      <= 1'b0;
            mex_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
            done_reg      <= done_next;
            mex_reg       <= mex_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg     <= position;
            val_reg     <= val_clamped;
            len_eff_reg <= len_eff;
        end
        if (state_reg == S_OLD_RD)
        begin
            old_reg <= elem_rdata;
        end
        if (state_reg == S_SCAN_RD)
        begin
            word_idx_reg <= open_word;
        end
    end

    mmt_ram #(
        .WIDTH (LEN_W),
        .DEPTH (MAX_LENGTH)
    ) u_elem_ram (
        .clk   (clk),
        .en    (elem_en),
        .we    (elem_we),
        .addr  (elem_addr),
        .wdata (elem_wdata),
        .rdata (elem_rdata)
    );

    mmt_ram #(
        .WIDTH (CNT_W),
        .DEPTH (CNT_DEPTH)
    ) u_cnt_ram (
        .clk   (clk),
        .en    (cnt_en),
        .we    (cnt_we),
        .addr  (cnt_addr),
        .wdata (cnt_wdata),
        .rdata (cnt_rdata)
    );

    mmt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_pres_ram (
        .clk   (clk),
        .en    (pres_en),
        .we    (pres_we),
        .addr  (pres_addr),
        .wdata (pres_wdata),
        .rdata (pres_rdata)
    );

    mmt_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (flag_upd),
        .open_word (open_word),
        .word_idx  (word_idx_reg),
        .word_data (pres_rdata),
        .len       (len_eff_reg),
        .mex       (scan_mex)
    );

endmodule

`default_nettype wire

@@ rtl/mmt_checker.sv @@
// Port-level checks for the multiset mex tracker and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mmt_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic                        busy,
    input  wire logic                        mode,
    input  wire logic [mmt_pkg::POS_W-1:0]   position,
    input  wire logic [mmt_pkg::VAL_W-1:0]   new_value,
    input  wire logic                        done,
    input  wire logic [mmt_pkg::LEN_W-1:0]   mex,
    input  wire logic                        cfg_valid,
    input  wire logic                        cfg_ready,
    input  wire logic [mmt_pkg::LEN_W-1:0]   cfg_data
);

    import mmt_pkg::*;

    a_mex_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (mex <= LEN_W'(MAX_LENGTH)))
        else $error("mex beyond the maximum length");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy afterwards");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

endmodule

bind multiset_mex_tracker mmt_checker u_mmt_checker (.*);

`default_nettype wire

@@ tb/sv/tb_multiset_mex_tracker.sv @@
// Self-checking testbench for the multiset mex tracker: predicted mex against each done beat.
`timescale 1ns / 1ps

module tb_multiset_mex_tracker;
    import mmt_pkg::*;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int WINDOW_MAX    = 40;
    localparam int PHASE_ITEMS   = 30;
    localparam int SWEEP_LOADS   = 192;
    localparam int SWEEP_UPDATES = 40;

    localparam logic [LEN_W-1:0] LEN_PARK     = '1;
    localparam logic [VAL_W-1:0] VAL_ALL_ONES = '1;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             mode;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] new_value;
    logic             done;
    logic [LEN_W-1:0] mex;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_data;

    logic [LEN_W-1:0] len_reg;
    logic [CNT_W-1:0] elem_val [MAX_LENGTH];
    logic [CNT_W-1:0] val_count [CNT_DEPTH];
    bit               val_seen [CNT_DEPTH];
    bit               loaded [MAX_LENGTH];
    bit               claimed [MAX_LENGTH];

    logic [LEN_W-1:0] mex_expected [$];
    logic [LEN_W-1:0] mex_want;
    int unsigned      work_pos [$];
    int unsigned      error_count;
    int unsigned      idle_cycles;
    bit               burst;

    multiset_mex_tracker u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .mode      (mode),
        .position  (position),
        .new_value (new_value),
        .done      (done),
        .mex       (mex),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned eff_len();
        int unsigned l;
        l = len_reg;
        if (l < 1) l = 1;
        if (l > MAX_LENGTH) l = MAX_LENGTH;
        return l;
    endfunction

    function automatic void bump_count(int unsigned v);
        if (val_count[v] != COUNT_MAX) val_count[v] = val_count[v] + 1'b1;
        val_seen[v] = 1'b1;
    endfunction

    function automatic void drop_count(int unsigned v);
        if (val_count[v] != '0) val_count[v] = val_count[v] - 1'b1;
        if (val_count[v] == '0) val_seen[v] = 1'b0;
    endfunction

    // Applies one item to the tracked multiset and returns the mex that follows.
    function automatic logic [LEN_W-1:0] predict_mex(logic m, logic [POS_W-1:0] p,
                                                     logic [VAL_W-1:0] raw);
        int unsigned l;
        int unsigned v;
        int unsigned found;
        l = eff_len();
        v = (raw > l) ? l : raw;
        if (m == MODE_LOAD)
        begin
            bump_count(v);
        end
        else if (elem_val[p] != v)
        begin
            drop_count(elem_val[p]);
            bump_count(v);
        end
        elem_val[p] = CNT_W'(v);
        found = l;
        for (int i = 0; i < l; i++)
        begin
            if (!val_seen[i])
            begin
                found = i;
                break;
            end
        end
        return LEN_W'(found);
    endfunction

    function automatic int unsigned pick_fresh();
        int unsigned p;
        do p = $urandom_range(0, MAX_LENGTH - 1); while (claimed[p]);
        return p;
    endfunction

    function automatic logic [VAL_W-1:0] draw_value(int unsigned l);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, l + 1);
            6, 7:             return $urandom();
            8:
            begin
                case ($urandom_range(0, 3))
                    0:       return l - 1;
                    1:       return l;
                    2:       return l + 1;
                    default: return VAL_ALL_ONES;
                endcase
            end
            default:          return $urandom_range(0, 2);
        endcase
    endfunction

    task automatic claim(int unsigned p);
        claimed[p] = 1'b1;
        work_pos.insert(work_pos.size(), p);
    endtask

    task automatic send_item(logic m, int unsigned p, logic [VAL_W-1:0] v);
        int unsigned gap;
        if ($urandom_range(0, 15) == 0) burst = !burst;
        gap = burst ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        mode      <= m;
        position  <= p[POS_W-1:0];
        new_value <= v;
        do @(posedge clk); while (busy);
        mex_expected.insert(mex_expected.size(), predict_mex(m, p[POS_W-1:0], v));
        if (m == MODE_LOAD) loaded[p] = 1'b1;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (mex_expected.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(logic [LEN_W-1:0] l);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= l;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        len_reg = l;
    endtask

    // Moves every loaded element of the work set to the top value so it drops out of later searches.
    task automatic park_work_set();
        write_length(LEN_PARK);
        foreach (work_pos[i])
        begin
            if (loaded[work_pos[i]]) send_item(MODE_UPDATE, work_pos[i], VAL_ALL_ONES);
        end
        work_pos.delete();
    endtask

    task automatic test_default_length();
        claim(0);
        claim(1);
        claim(2);
        claim(3);
        claim(341);
        claim(682);
        claim(1023);
        send_item(MODE_LOAD, 0, 32'd0);
        send_item(MODE_LOAD, 1023, VAL_ALL_ONES);
        send_item(MODE_LOAD, 341, 32'h5555_5555);
        send_item(MODE_LOAD, 682, 32'hAAAA_AAAA);
        send_item(MODE_LOAD, 1, 32'd1);
        send_item(MODE_LOAD, 2, 32'd1024);
        send_item(MODE_LOAD, 3, 32'd1023);
        send_item(MODE_UPDATE, 1, 32'd1);
        send_item(MODE_UPDATE, 2, 32'd2);
        send_item(MODE_UPDATE, 1, 32'd5);
        send_item(MODE_LOAD, 1023, 32'd7);
        send_item(MODE_UPDATE, 0, 32'd1024);
        send_item(MODE_UPDATE, 3, VAL_ALL_ONES);
    endtask

    task automatic test_length_extremes();
        claim(4);
        claim(5);
        write_length(11'd0);
        send_item(MODE_UPDATE, 1, 32'd7);
        send_item(MODE_LOAD, 4, 32'd0);
        write_length(11'd1);
        send_item(MODE_UPDATE, 4, 32'd1);
        send_item(MODE_UPDATE, 2, 32'd0);
        write_length(11'd2047);
        send_item(MODE_UPDATE, 3, 32'd2000);
        send_item(MODE_LOAD, 5, 32'd1023);
        write_length(11'd1025);
        send_item(MODE_UPDATE, 5, 32'd1025);
        write_length(11'd1024);
        send_item(MODE_UPDATE, 0, 32'd1024);
        send_item(MODE_UPDATE, 1, 32'd0);
        park_work_set();
    endtask

    task automatic test_random_phase(logic [LEN_W-1:0] l);
        int unsigned eff;
        int unsigned width;
        int unsigned k;
        logic [VAL_W-1:0] v;
        write_length(l);
        eff   = eff_len();
        width = (2 * eff + 3 > WINDOW_MAX) ? WINDOW_MAX : 2 * eff + 3;
        repeat (width) claim(pick_fresh());
        repeat (PHASE_ITEMS)
        begin
            k = work_pos[$urandom_range(0, width - 1)];
            v = draw_value(eff);
            if (!loaded[k] || $urandom_range(0, 19) == 0) send_item(MODE_LOAD, k, v);
            else send_item(MODE_UPDATE, k, v);
            if ($urandom_range(0, 59) == 0) wait_drained();
        end
        park_work_set();
    endtask

    task automatic test_full_sweep();
        write_length(11'd1024);
        for (int p = 0; p < SWEEP_LOADS; p++) send_item(MODE_LOAD, p, p);
        repeat (SWEEP_UPDATES)
            send_item(MODE_UPDATE, $urandom_range(0, SWEEP_LOADS - 1), draw_value(1024));
    endtask

    initial
    begin
        len_reg = LEN_RESET;
        for (int i = 0; i < MAX_LENGTH; i++)
        begin
            elem_val[i] = '0;
            loaded[i]   = 1'b0;
            claimed[i]  = 1'b0;
        end
        for (int i = 0; i < CNT_DEPTH; i++)
        begin
            val_count[i] = '0;
            val_seen[i]  = 1'b0;
        end
        error_count = 0;
        burst       = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        mode        = MODE_LOAD;
        position    = '0;
        new_value   = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_default_length();
        test_length_extremes();
        test_random_phase(11'd3);
        test_random_phase(11'd1);
        test_random_phase(11'd8);
        test_random_phase(11'd2);
        test_random_phase(11'd31);
        test_random_phase(11'd5);
        test_random_phase(11'd0);
        test_random_phase(11'd16);
        test_random_phase(11'd1025);
        test_random_phase(11'd64);
        test_random_phase(11'd2047);
        test_full_sweep();
        wait_drained();

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (mex_expected.size() == 0)
            begin
                $display("%0t: mex beat with none expected, got %0d", $time, mex);
                error_count++;
            end
            else
            begin
                mex_want = mex_expected.pop_front();
                if (mex !== mex_want)
                begin
                    $display("%0t: mex mismatch, expected %0d, got %0d",
                             $time, mex_want, mex);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule
